// ===== hw/rtl/icalc_pkg.sv =====
// Shared types and constants for the integer calculator ALU.
// Used by icalc_div, icalc_pow and integer_calc_alu_with_accumulator.
package icalc_pkg;

  localparam int unsigned DataWidth = 32;
  localparam int unsigned CntW      = $clog2(DataWidth);

  typedef logic [DataWidth-1:0] word_t;

  // Command codes; codes 6 and 7 are no operation.
  typedef enum logic [2:0] {
    CMD_ADD = 3'd0,
    CMD_SUB = 3'd1,
    CMD_MUL = 3'd2,
    CMD_DIV = 3'd3,
    CMD_POW = 3'd4,
    CMD_MOD = 3'd5
  } cmd_e;

  // Request into the multiply / power sequencer.
  typedef struct packed {
    logic start;   // begin a new job
    logic mul_only; // single product instead of square-and-multiply
  } pow_req_t;

endpackage

// ===== hw/rtl/icalc_div.sv =====
// Radix-2 restoring divider on unsigned magnitudes, one quotient bit a cycle.
// Depends on icalc_pkg.
module icalc_div (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                start_i,
  input  icalc_pkg::word_t    dividend_i,
  input  icalc_pkg::word_t    divisor_i,
  output logic                done_o,
  output icalc_pkg::word_t    quotient_o,
  output icalc_pkg::word_t    remainder_o
);

  logic                        busy_q;
  logic [icalc_pkg::CntW-1:0]  cnt_q;
  icalc_pkg::word_t            rem_q;
  icalc_pkg::word_t            quo_q;
  icalc_pkg::word_t            dvs_q;

  logic [icalc_pkg::DataWidth:0] rem_sh;
  logic [icalc_pkg::DataWidth:0] diff;

  assign rem_sh = {rem_q, quo_q[icalc_pkg::DataWidth-1]};
  assign diff   = rem_sh - {1'b0, dvs_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_o <= 1'b0;
      cnt_q  <= '0;
      rem_q  <= '0;
      quo_q  <= '0;
      dvs_q  <= '0;
    end else begin
      done_o <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
        rem_q  <= '0;
        quo_q  <= dividend_i;
        dvs_q  <= divisor_i;
      end else if (busy_q) begin
        // keep the partial remainder when the trial subtract goes negative
        if (!diff[icalc_pkg::DataWidth]) begin
          rem_q <= diff[icalc_pkg::DataWidth-1:0];
          quo_q <= {quo_q[icalc_pkg::DataWidth-2:0], 1'b1};
        end else begin
          rem_q <= rem_sh[icalc_pkg::DataWidth-1:0];
          quo_q <= {quo_q[icalc_pkg::DataWidth-2:0], 1'b0};
        end
        cnt_q <= cnt_q + 1'b1;
        if (cnt_q == icalc_pkg::CntW'(icalc_pkg::DataWidth - 1)) begin
          busy_q <= 1'b0;
          done_o <= 1'b1;
        end
      end
    end
  end

  assign quotient_o  = quo_q;
  assign remainder_o = rem_q;

endmodule

// ===== hw/rtl/icalc_pow.sv =====
// Square-and-multiply sequencer around one shared 32x32 multiplier.
// Also forms a single wrapped product. Depends on icalc_pkg.
module icalc_pow (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  icalc_pkg::pow_req_t req_i,
  input  icalc_pkg::word_t    base_i,
  input  icalc_pkg::word_t    expo_i,
  output logic                done_o,
  output icalc_pkg::word_t    result_o
);

  logic             busy_q;
  logic             sq_phase_q; // 0: multiply into product, 1: square the base
  icalc_pkg::word_t acc_q;
  icalc_pkg::word_t sq_q;
  icalc_pkg::word_t exp_q;

  icalc_pkg::word_t mul_x;
  icalc_pkg::word_t prod;

  // one multiplier, operands picked by phase; low word only
  assign mul_x = sq_phase_q ? sq_q : acc_q;
  assign prod  = mul_x * sq_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q     <= 1'b0;
      sq_phase_q <= 1'b0;
      done_o     <= 1'b0;
      acc_q      <= '0;
      sq_q       <= '0;
      exp_q      <= '0;
    end else begin
      done_o <= 1'b0;
      if (req_i.start) begin
        busy_q     <= 1'b1;
        sq_phase_q <= 1'b0;
        if (req_i.mul_only) begin
          // one round with exponent 1: product = base * expo
          acc_q <= base_i;
          sq_q  <= expo_i;
          exp_q <= icalc_pkg::word_t'(1);
        end else begin
          acc_q <= icalc_pkg::word_t'(1);
          sq_q  <= base_i;
          exp_q <= expo_i;
        end
      end else if (busy_q) begin
        if (!sq_phase_q) begin
          if (exp_q[0]) begin
            acc_q <= prod;
          end
          if (exp_q[icalc_pkg::DataWidth-1:1] == '0) begin
            busy_q <= 1'b0;
            done_o <= 1'b1;
          end else begin
            sq_phase_q <= 1'b1;
          end
        end else begin
          sq_q       <= prod;
          exp_q      <= exp_q >> 1;
          sq_phase_q <= 1'b0;
        end
      end
    end
  end

  assign result_o = acc_q;

endmodule

// ===== hw/rtl/integer_calc_alu_with_accumulator.sv =====
// Top level of the integer calculator ALU with result accumulator.
// Depends on icalc_pkg, icalc_div and icalc_pow.
//
// Usage: one input word carries a command, two signed 32-bit operands and two
// "operand given" flags; one output word returns the result (also the new
// accumulator value but for no-op and a zero divisor) and a divide-by-zero
// flag. One given operand is the second, the accumulator the first; none gives zeros.
// Channels: slave stream (s_axis_*) in, master stream (m_axis_*) out, each
// word moving when tvalid and tready are both high.
// Steps: an accepted word enters S_EXEC, where add, sub, no-op, a zero
// divisor, a zero exponent and a negative exponent finish; mul and power go
// on to S_POW, div and mod to S_DIV (the radix-2 divider resolves one quotient
// bit a cycle); power shares one multiplier between the multiply and square
// steps. Every word then passes S_DONE, which loads the output register.
// Throughput: one word in flight; s_axis_tready_o is high only while the
// sequencer is idle. A finished word waits in the output register, and the
// next input word is accepted meanwhile; a new result holds until the
// output register is free.
// Reset clears the accumulator to zero and drops any pending output word.
module integer_calc_alu_with_accumulator (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [63:0] s_axis_tdata_i,  // [31:0] first_value, [63:32] second_value
  input  logic [4:0]  s_axis_tuser_i,  // [2:0] cmd, [3] first_given, [4] second_given
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [31:0] m_axis_tdata_o,  // [31:0] result
  output logic [0:0]  m_axis_tuser_o   // [0] divide_by_zero
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_EXEC,
    S_DIV,
    S_POW,
    S_DONE
  } state_e;

  state_e               state_q;
  icalc_pkg::cmd_e      cmd_q;
  icalc_pkg::word_t     a_q;
  icalc_pkg::word_t     b_q;
  icalc_pkg::word_t     acc_q;
  icalc_pkg::word_t     res_q;
  logic                 dz_q;
  logic                 store_q;
  logic                 out_valid_q;
  icalc_pkg::word_t     out_data_q;
  logic                 out_dz_q;

  // operand selection at accept time
  logic                 in_accept;
  logic                 first_given;
  logic                 second_given;
  icalc_pkg::word_t     first_value;
  icalc_pkg::word_t     second_value;
  icalc_pkg::word_t     sel_a;
  icalc_pkg::word_t     sel_b;

  // decode of the execute step
  state_e               exec_state;
  icalc_pkg::word_t     exec_res;
  logic                 exec_dz;
  logic                 exec_store;

  // shared units
  logic                 div_start;
  logic                 div_done;
  icalc_pkg::word_t     div_quo;
  icalc_pkg::word_t     div_rem;
  icalc_pkg::word_t     mag_a;
  icalc_pkg::word_t     mag_b;
  icalc_pkg::pow_req_t  pow_req;
  logic                 pow_done;
  icalc_pkg::word_t     pow_res;

  logic                 a_neg;
  logic                 b_neg;
  logic                 out_free;

  assign s_axis_tready_o = (state_q == S_IDLE);
  assign in_accept       = s_axis_tvalid_i && s_axis_tready_o;

  assign first_value  = s_axis_tdata_i[31:0];
  assign second_value = s_axis_tdata_i[63:32];
  assign first_given  = s_axis_tuser_i[3];
  assign second_given = s_axis_tuser_i[4];

  always_comb begin
    if (first_given && second_given) begin
      sel_a = first_value;
      sel_b = second_value;
    end else if (second_given) begin
      sel_a = acc_q;
      sel_b = second_value;
    end else if (first_given) begin
      sel_a = acc_q;
      sel_b = first_value;
    end else begin
      sel_a = '0;
      sel_b = '0;
    end
  end

  assign a_neg = a_q[icalc_pkg::DataWidth-1];
  assign b_neg = b_q[icalc_pkg::DataWidth-1];
  assign mag_a = a_neg ? (icalc_pkg::word_t'(0) - a_q) : a_q;
  assign mag_b = b_neg ? (icalc_pkg::word_t'(0) - b_q) : b_q;

  // finish the one-step commands here, hand the rest to a shared unit
  always_comb begin
    exec_state = S_DONE;
    exec_res   = res_q;
    exec_dz    = 1'b0;
    exec_store = 1'b1;
    case (cmd_q) inside
      icalc_pkg::CMD_ADD: exec_res = a_q + b_q;
      icalc_pkg::CMD_SUB: exec_res = a_q - b_q;
      icalc_pkg::CMD_MUL: exec_state = S_POW;
      icalc_pkg::CMD_DIV, icalc_pkg::CMD_MOD: begin
        if (b_q == '0) begin
          // zero divisor: flag it, return 0, keep the accumulator
          exec_res   = '0;
          exec_dz    = 1'b1;
          exec_store = 1'b0;
        end else begin
          exec_state = S_DIV;
        end
      end
      icalc_pkg::CMD_POW: begin
        if (b_q == '0) begin
          exec_res = icalc_pkg::word_t'(1);
        end else if (b_neg) begin
          // negative exponent returns the base
          exec_res = a_q;
        end else begin
          exec_state = S_POW;
        end
      end
      default: begin
        // no operation: echo the accumulator
        exec_res   = acc_q;
        exec_store = 1'b0;
      end
    endcase
  end

  // launch the units from the execute state
  assign div_start = (state_q == S_EXEC) && (b_q != '0) &&
                     ((cmd_q == icalc_pkg::CMD_DIV) || (cmd_q == icalc_pkg::CMD_MOD));
  assign pow_req.start    = (state_q == S_EXEC) &&
                            ((cmd_q == icalc_pkg::CMD_MUL) ||
                             ((cmd_q == icalc_pkg::CMD_POW) && (b_q != '0) && !b_neg));
  assign pow_req.mul_only = (cmd_q == icalc_pkg::CMD_MUL);

  icalc_div u_div (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start_i     (div_start),
    .dividend_i  (mag_a),
    .divisor_i   (mag_b),
    .done_o      (div_done),
    .quotient_o  (div_quo),
    .remainder_o (div_rem)
  );

  icalc_pow u_pow (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .req_i    (pow_req),
    .base_i   (a_q),
    .expo_i   (b_q),
    .done_o   (pow_done),
    .result_o (pow_res)
  );

  assign out_free = !out_valid_q || m_axis_tready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      cmd_q       <= icalc_pkg::CMD_ADD;
      a_q         <= '0;
      b_q         <= '0;
      acc_q       <= '0;
      res_q       <= '0;
      dz_q        <= 1'b0;
      store_q     <= 1'b0;
      out_valid_q <= 1'b0;
      out_data_q  <= '0;
      out_dz_q    <= 1'b0;
    end else begin
      // drop the output word once it is taken, unless a new one replaces it
      if (out_valid_q && m_axis_tready_i && (state_q != S_DONE)) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        S_IDLE: begin
          if (in_accept) begin
            cmd_q   <= icalc_pkg::cmd_e'(s_axis_tuser_i[2:0]);
            a_q     <= sel_a;
            b_q     <= sel_b;
            state_q <= S_EXEC;
          end
        end
        S_EXEC: begin
          res_q   <= exec_res;
          dz_q    <= exec_dz;
          store_q <= exec_store;
          state_q <= exec_state;
        end
        S_DIV: begin
          if (div_done) begin
            if (cmd_q == icalc_pkg::CMD_DIV) begin
              res_q <= (a_neg != b_neg) ? (icalc_pkg::word_t'(0) - div_quo) : div_quo;
            end else begin
              res_q <= a_neg ? (icalc_pkg::word_t'(0) - div_rem) : div_rem;
            end
            state_q <= S_DONE;
          end
        end
        S_POW: begin
          if (pow_done) begin
            res_q   <= pow_res;
            state_q <= S_DONE;
          end
        end
        S_DONE: begin
          // hold until the output register is free
          if (out_free) begin
            out_valid_q <= 1'b1;
            out_data_q  <= res_q;
            out_dz_q    <= dz_q;
            if (store_q) begin
              acc_q <= res_q;
            end
            state_q <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  assign m_axis_tvalid_o   = out_valid_q;
  assign m_axis_tdata_o    = out_data_q;
  assign m_axis_tuser_o[0] = out_dz_q;

endmodule
